// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file lap_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted
`define LAP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that is also checked during reset
`define LAP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/lap_pkg.sv -----
`timescale 1ns / 1ps
// Types, constants and the arctangent table for the local aligned projection
package lap_pkg;

    localparam logic signed [33:0] ONE_Q30   = 34'sd1073741824;
    localparam logic signed [33:0] INV_GAIN  = 34'sd652032874;
    localparam logic [22:0]        EQ_RADIUS = 23'd6378137;
    // floor(2^54 / radius): reciprocal for the metres to arcsine argument step
    localparam logic [31:0]        DIV_K     = 32'(64'd18014398509481984 / 64'd6378137);
    // smallest magnitude whose argument exceeds unity
    localparam logic [33:0]        SAT_LIMIT = 34'd408200769;
    localparam logic [61:0]        SQ_TOP    = 62'd1 << 60;

    localparam logic [2:0] REG_ORIGIN_LAT    = 3'd0;
    localparam logic [2:0] REG_ORIGIN_LON    = 3'd1;
    localparam logic [2:0] REG_HEADING_COS   = 3'd2;
    localparam logic [2:0] REG_HEADING_SIN   = 3'd3;
    localparam logic [2:0] REG_LON_SCALE     = 3'd4;
    localparam logic [2:0] REG_LON_SCALE_INV = 3'd5;

    localparam logic OP_FWD = 1'b0;
    localparam logic OP_INV = 1'b1;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } cv_t;

    typedef struct packed {
        logic [61:0]        n;
        logic [61:0]        r;
        logic signed [33:0] a;
    } sq_t;

    typedef struct packed {
        logic        op;
        logic        err;
        logic [31:0] elev;
    } meta_t;

    function automatic logic signed [33:0] atan_of(input int i);
        logic signed [33:0] v;
        unique case (i)
            0:  v = 34'sd536870912;
            1:  v = 34'sd316933406;
            2:  v = 34'sd167458907;
            3:  v = 34'sd85004756;
            4:  v = 34'sd42667331;
            5:  v = 34'sd21354465;
            6:  v = 34'sd10679838;
            7:  v = 34'sd5340245;
            8:  v = 34'sd2670163;
            9:  v = 34'sd1335087;
            10: v = 34'sd667544;
            11: v = 34'sd333772;
            12: v = 34'sd166886;
            13: v = 34'sd83443;
            14: v = 34'sd41722;
            15: v = 34'sd20861;
            16: v = 34'sd10430;
            17: v = 34'sd5215;
            18: v = 34'sd2608;
            19: v = 34'sd1304;
            20: v = 34'sd652;
            21: v = 34'sd326;
            22: v = 34'sd163;
            23: v = 34'sd81;
            24: v = 34'sd41;
            25: v = 34'sd20;
            26: v = 34'sd10;
            27: v = 34'sd5;
            28: v = 34'sd3;
            29: v = 34'sd1;
            30: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/lap_sqrt_cell.sv -----
`timescale 1ns / 1ps
// One digit stage of the pipelined integer square root
module lap_sqrt_cell #(
    parameter int BIT_POS = 60
) (
    input  logic         clk,
    input  logic         en,
    input  lap_pkg::sq_t d_in,
    output lap_pkg::sq_t d_out
);
    import lap_pkg::*;

    localparam logic [61:0] BIT_VAL = 62'd1 << BIT_POS;

    sq_t         q_reg;
    sq_t         q_next;
    logic [61:0] trial;

    always_comb
    begin
        trial    = d_in.r + BIT_VAL;
        q_next.a = d_in.a;
        if (d_in.n >= trial)
        begin
            q_next.n = d_in.n - trial;
            q_next.r = (d_in.r >> 1) + BIT_VAL;
        end
        else
        begin
            q_next.n = d_in.n;
            q_next.r = d_in.r >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign d_out = q_reg;

endmodule

// ----- design/lap_cordic_cell.sv -----
`timescale 1ns / 1ps
// One CORDIC micro-rotation stage, rotation or vectoring per beat
module lap_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic         clk,
    input  logic         en,
    input  logic         rotate,
    input  lap_pkg::cv_t d_in,
    output lap_pkg::cv_t d_out
);
    import lap_pkg::*;

    localparam logic signed [33:0] ANGLE = atan_of(SHIFT);

    cv_t  q_reg;
    cv_t  q_next;
    logic dir;

    always_comb
    begin
        // rotation steers on the residual angle, vectoring on the sign of y
        dir = rotate ? !d_in.z[33] : d_in.y[33];
        if (dir)
        begin
            q_next.x = d_in.x - (d_in.y >>> SHIFT);
            q_next.y = d_in.y + (d_in.x >>> SHIFT);
            q_next.z = d_in.z - ANGLE;
        end
        else
        begin
            q_next.x = d_in.x + (d_in.y >>> SHIFT);
            q_next.y = d_in.y - (d_in.x >>> SHIFT);
            q_next.z = d_in.z + ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign d_out = q_reg;

endmodule

// ----- design/local_aligned_projection_top.sv -----
`timescale 1ns / 1ps
// Top level of the local aligned projection pipeline
// Takes one point per clock while in_stall is low and returns one result per
// point, in order, after front stages of heading rotation and arcsine argument
// scaling, a 31-cell square-root chain, one CORDIC cell per stage (two chains
// side by side, one per axis), and back stages of scaling, rotation and origin
// offset. Both directions share the same chains, so the latency does not
// depend on op. The output register lets new points enter while a result
// waits; the pipe stops only when its last stage is full behind a held result.
// Configuration writes take effect at once and are accepted every cycle.
module local_aligned_projection_top #(
    parameter int CORDIC_STAGES = 24,
    parameter int ANGLE_BITS    = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic signed [31:0] lat_in,
    input  logic signed [31:0] lon_in,
    input  logic signed [31:0] x_in,
    input  logic signed [31:0] y_in,
    input  logic signed [31:0] elev_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] x_out,
    output logic signed [31:0] y_out,
    output logic signed [31:0] lat_out,
    output logic signed [31:0] lon_out,
    output logic signed [31:0] elev_out,
    output logic               domain_error,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import lap_pkg::*;

    localparam logic [31:0] ANG_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
    localparam int ST_P5      = 4;
    localparam int ST_P6      = 5;
    localparam int ST_SQ_END  = 37;
    localparam int ST_COR_END = ST_SQ_END + CORDIC_STAGES;
    localparam int PIPE_LEN   = 44 + CORDIC_STAGES;

    // configuration
    logic signed [31:0] origin_lat_reg;
    logic signed [31:0] origin_lon_reg;
    logic signed [31:0] heading_cos_reg;
    logic signed [31:0] heading_sin_reg;
    logic [30:0]        lon_scale_reg;
    logic [31:0]        lon_scale_inv_reg;
    logic signed [31:0] hc;
    logic signed [31:0] hs;
    logic signed [31:0] hs_neg;

    // flow control
    logic               en;
    logic               out_take;
    logic               v_reg [0:PIPE_LEN-1];
    meta_t              meta_reg [0:PIPE_LEN-1];

    // arcsine argument stages, lane 0 is the north axis, lane 1 the east axis
    logic signed [63:0] p1_a_reg [0:1];
    logic signed [63:0] p1_a_next [0:1];
    logic signed [63:0] p1_b_reg [0:1];
    logic signed [63:0] p1_b_next [0:1];
    logic signed [33:0] fz_reg [0:ST_P6][0:1];
    logic signed [33:0] fz_next [0:1];
    logic signed [33:0] p2_v_reg [0:1];
    logic signed [33:0] p2_v_next [0:1];
    logic               p3_neg_reg [0:1];
    logic               p3_sat_reg [0:1];
    logic [28:0]        p3_mc_reg [0:1];
    logic               p3_sat_next [0:1];
    logic [28:0]        p3_mc_next [0:1];
    logic [60:0]        p4_mk_reg [0:1];
    logic               p4_neg_reg [0:1];
    logic               p4_sat_reg [0:1];
    logic [28:0]        p4_mc_reg [0:1];
    logic [30:0]        p5_q0_reg [0:1];
    logic [53:0]        p5_qr_reg [0:1];
    logic [28:0]        p5_mc_reg [0:1];
    logic               p5_neg_reg [0:1];
    logic               p5_sat_reg [0:1];
    logic signed [31:0] p6_a_reg [0:1];
    logic signed [31:0] p6_a_next [0:1];
    sq_t                p7_sq_reg [0:1];
    sq_t                p7_sq_next [0:1];
    logic               err_next;

    sq_t                sq_link [0:31][0:1];
    cv_t                cv_link [0:CORDIC_STAGES][0:1];

    // output side stages
    logic signed [55:0] q1_slr_reg;
    logic signed [62:0] q1_sol_reg;
    logic signed [31:0] q1_zq0_reg;
    logic signed [64:0] q1_lp_reg;
    logic signed [55:0] q1_slr_next;
    logic signed [62:0] q1_sol_next;
    logic signed [64:0] q1_lp_next;
    logic signed [55:0] q2_ty;
    logic signed [62:0] q2_tp;
    logic signed [64:0] q2_tl;
    logic signed [31:0] q2_y_reg;
    logic signed [31:0] q2_p_reg;
    logic signed [31:0] q2_lat_reg;
    logic signed [31:0] q2_dlon_reg;
    logic signed [55:0] q3_pr_reg;
    logic signed [55:0] q3_pr_next;
    logic signed [31:0] q3_y_reg;
    logic signed [31:0] q3_lat_reg;
    logic signed [31:0] q3_lon_reg;
    logic signed [55:0] q4_tx;
    logic signed [31:0] q4_x_reg;
    logic signed [31:0] q4_y_reg;
    logic signed [31:0] q4_lat_reg;
    logic signed [31:0] q4_lon_reg;
    logic signed [63:0] q5_m0_reg;
    logic signed [63:0] q5_m1_reg;
    logic signed [63:0] q5_m2_reg;
    logic signed [63:0] q5_m3_reg;
    logic signed [63:0] q5_m0_next;
    logic signed [63:0] q5_m1_next;
    logic signed [63:0] q5_m2_next;
    logic signed [63:0] q5_m3_next;
    logic signed [31:0] q5_lat_reg;
    logic signed [31:0] q5_lon_reg;
    logic signed [31:0] q6_x_reg;
    logic signed [31:0] q6_y_reg;
    logic signed [31:0] q6_lat_reg;
    logic signed [31:0] q6_lon_reg;

    logic               out_valid_reg;
    logic signed [31:0] x_out_reg;
    logic signed [31:0] y_out_reg;
    logic signed [31:0] lat_out_reg;
    logic signed [31:0] lon_out_reg;
    logic signed [31:0] elev_out_reg;
    logic               domain_error_reg;

    function automatic logic signed [31:0] clamp_q30(input logic signed [31:0] v);
        logic signed [31:0] r;
        if (v > 32'sd1073741824)
            r = 32'sd1073741824;
        else if (v < -32'sd1073741824)
            r = -32'sd1073741824;
        else
            r = v;
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_y(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > ONE_Q30)
            r = 32'sd1073741824;
        else if (v < -ONE_Q30)
            r = -32'sd1073741824;
        else
            r = v[31:0];
        return r;
    endfunction

    // quantise the angle, then fold it into [-pi/2, pi/2] for the sine
    function automatic logic signed [33:0] fold_angle(input logic [31:0] d);
        logic signed [33:0] q;
        q = 34'(signed'(d & ANG_MASK));
        if (q > ONE_Q30)
            q = 34'sd2147483648 - q;
        else if (q < -ONE_Q30)
            q = -34'sd2147483648 - q;
        return q;
    endfunction

    function automatic logic signed [31:0] sat_rnd30(input logic signed [63:0] v);
        logic signed [63:0] t;
        logic signed [33:0] r;
        logic signed [31:0] o;
        t = v + 64'sd536870912;
        r = t[63:30];
        if (r > 34'sd2147483647)
            o = 32'sh7fffffff;
        else if (r < -34'sd2147483648)
            o = 32'sh80000000;
        else
            o = r[31:0];
        return o;
    endfunction

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_lat_reg    <= '0;
            origin_lon_reg    <= '0;
            heading_cos_reg   <= 32'sd1073741824;
            heading_sin_reg   <= '0;
            lon_scale_reg     <= 31'd1073741824;
            lon_scale_inv_reg <= 32'd16777216;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ORIGIN_LAT:    origin_lat_reg    <= cfg_data;
                REG_ORIGIN_LON:    origin_lon_reg    <= cfg_data;
                REG_HEADING_COS:   heading_cos_reg   <= cfg_data;
                REG_HEADING_SIN:   heading_sin_reg   <= cfg_data;
                REG_LON_SCALE:     lon_scale_reg     <= cfg_data[30:0];
                REG_LON_SCALE_INV: lon_scale_inv_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign hc     = clamp_q30(heading_cos_reg);
    assign hs     = clamp_q30(heading_sin_reg);
    assign hs_neg = -hs;

    // flow control: the pipe moves unless a held result blocks its last stage
    assign out_take = !out_valid_reg || !out_stall;
    assign en       = out_take || !v_reg[PIPE_LEN-1];
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_LEN; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < PIPE_LEN; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // front stages
    always_comb
    begin
        logic [33:0] mag;
        logic [53:0] rem;
        logic [30:0] q;
        logic [30:0] a;
        logic signed [63:0] sqr;

        p1_a_next[0] = y_in * hc;
        p1_b_next[0] = x_in * hs_neg;
        p1_a_next[1] = x_in * hc;
        p1_b_next[1] = y_in * hs;
        fz_next[0]   = fold_angle(lat_in - origin_lat_reg);
        fz_next[1]   = fold_angle(lon_in - origin_lon_reg);
        err_next     = (p5_sat_reg[0] || p5_sat_reg[1]) && (meta_reg[ST_P5].op == OP_INV);

        for (int l = 0; l < 2; l++)
        begin
            p2_v_next[l] = 34'((p1_a_reg[l] + p1_b_reg[l] + 64'sd536870912) >>> 30);

            mag            = p2_v_reg[l][33] ? 34'(-p2_v_reg[l]) : p2_v_reg[l];
            p3_sat_next[l] = (mag >= SAT_LIMIT);
            p3_mc_next[l]  = p3_sat_next[l] ? 29'd0 : mag[28:0];

            // reciprocal estimate is low by at most one
            rem = {1'b0, p5_mc_reg[l], 24'd0} - p5_qr_reg[l];
            q   = p5_q0_reg[l] + 31'(rem >= 54'(EQ_RADIUS));
            a   = p5_sat_reg[l] ? 31'd1073741824 : q;
            p6_a_next[l] = p5_neg_reg[l] ? -$signed({1'b0, a}) : $signed({1'b0, a});

            sqr             = p6_a_reg[l] * p6_a_reg[l];
            p7_sq_next[l].n = SQ_TOP - sqr[61:0];
            p7_sq_next[l].r = '0;
            p7_sq_next[l].a = (meta_reg[ST_P6].op == OP_INV) ? 34'(p6_a_reg[l])
                                                              : fz_reg[ST_P6][l];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_reg[0].op   <= op;
            meta_reg[0].err  <= 1'b0;
            meta_reg[0].elev <= elev_in;
            for (int k = 1; k < PIPE_LEN; k++)
            begin
                meta_reg[k] <= meta_reg[k-1];
            end
            meta_reg[ST_P6].err <= err_next;

            for (int l = 0; l < 2; l++)
            begin
                p1_a_reg[l]   <= p1_a_next[l];
                p1_b_reg[l]   <= p1_b_next[l];
                fz_reg[0][l]  <= fz_next[l];
                for (int k = 1; k <= ST_P6; k++)
                begin
                    fz_reg[k][l] <= fz_reg[k-1][l];
                end
                p2_v_reg[l]   <= p2_v_next[l];
                p3_neg_reg[l] <= p2_v_reg[l][33];
                p3_sat_reg[l] <= p3_sat_next[l];
                p3_mc_reg[l]  <= p3_mc_next[l];
                p4_mk_reg[l]  <= p3_mc_reg[l] * DIV_K;
                p4_neg_reg[l] <= p3_neg_reg[l];
                p4_sat_reg[l] <= p3_sat_reg[l];
                p4_mc_reg[l]  <= p3_mc_reg[l];
                p5_q0_reg[l]  <= p4_mk_reg[l][60:30];
                p5_qr_reg[l]  <= p4_mk_reg[l][60:30] * EQ_RADIUS;
                p5_mc_reg[l]  <= p4_mc_reg[l];
                p5_neg_reg[l] <= p4_neg_reg[l];
                p5_sat_reg[l] <= p4_sat_reg[l];
                p6_a_reg[l]   <= p6_a_next[l];
                p7_sq_reg[l]  <= p7_sq_next[l];
            end
        end
    end

    // square-root and CORDIC cell chains
    genvar g;
    genvar ln;
    generate
        for (ln = 0; ln < 2; ln++)
        begin : g_lane
            assign sq_link[0][ln] = p7_sq_reg[ln];

            for (g = 0; g < 31; g++)
            begin : g_sq
                lap_sqrt_cell #(
                    .BIT_POS(60 - 2 * g)
                ) u_sq (
                    .clk   (clk),
                    .en    (en),
                    .d_in  (sq_link[g][ln]),
                    .d_out (sq_link[g+1][ln])
                );
            end

            always_comb
            begin
                if (meta_reg[ST_SQ_END].op == OP_INV)
                begin
                    cv_link[0][ln].x = {3'b000, sq_link[31][ln].r[30:0]};
                    cv_link[0][ln].y = sq_link[31][ln].a;
                    cv_link[0][ln].z = '0;
                end
                else
                begin
                    cv_link[0][ln].x = INV_GAIN;
                    cv_link[0][ln].y = '0;
                    cv_link[0][ln].z = sq_link[31][ln].a;
                end
            end

            for (g = 0; g < CORDIC_STAGES; g++)
            begin : g_cor
                lap_cordic_cell #(
                    .SHIFT(g)
                ) u_cor (
                    .clk    (clk),
                    .en     (en),
                    .rotate (meta_reg[ST_SQ_END + g].op == OP_FWD),
                    .d_in   (cv_link[g][ln]),
                    .d_out  (cv_link[g+1][ln])
                );
            end
        end
    endgenerate

    // back stages
    always_comb
    begin
        q1_slr_next = clamp_y(cv_link[CORDIC_STAGES][0].y) * $signed({1'b0, EQ_RADIUS});
        q1_sol_next = clamp_y(cv_link[CORDIC_STAGES][1].y) * $signed({1'b0, lon_scale_reg});
        q1_lp_next  = $signed(cv_link[CORDIC_STAGES][1].z[31:0] & ANG_MASK)
                      * $signed({1'b0, lon_scale_inv_reg});
        q2_ty       = q1_slr_reg + 56'sd8388608;
        q2_tp       = q1_sol_reg + 63'sd536870912;
        q2_tl       = q1_lp_reg + 65'sd8388608;
        q3_pr_next  = q2_p_reg * $signed({1'b0, EQ_RADIUS});
        q4_tx       = q3_pr_reg + 56'sd8388608;
        q5_m0_next  = q4_x_reg * hc;
        q5_m1_next  = q4_y_reg * hs;
        q5_m2_next  = q4_x_reg * hs;
        q5_m3_next  = q4_y_reg * hc;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_slr_reg  <= q1_slr_next;
            q1_sol_reg  <= q1_sol_next;
            q1_zq0_reg  <= $signed(cv_link[CORDIC_STAGES][0].z[31:0] & ANG_MASK);
            q1_lp_reg   <= q1_lp_next;
            q2_y_reg    <= q2_ty[55:24];
            q2_p_reg    <= q2_tp[61:30];
            q2_lat_reg  <= origin_lat_reg + q1_zq0_reg;
            q2_dlon_reg <= q2_tl[55:24];
            q3_pr_reg   <= q3_pr_next;
            q3_y_reg    <= q2_y_reg;
            q3_lat_reg  <= q2_lat_reg;
            q3_lon_reg  <= origin_lon_reg + q2_dlon_reg;
            q4_x_reg    <= q4_tx[55:24];
            q4_y_reg    <= q3_y_reg;
            q4_lat_reg  <= q3_lat_reg;
            q4_lon_reg  <= q3_lon_reg;
            q5_m0_reg   <= q5_m0_next;
            q5_m1_reg   <= q5_m1_next;
            q5_m2_reg   <= q5_m2_next;
            q5_m3_reg   <= q5_m3_next;
            q5_lat_reg  <= q4_lat_reg;
            q5_lon_reg  <= q4_lon_reg;
            q6_x_reg    <= sat_rnd30(q5_m0_reg - q5_m1_reg);
            q6_y_reg    <= sat_rnd30(q5_m2_reg + q5_m3_reg);
            q6_lat_reg  <= q5_lat_reg;
            q6_lon_reg  <= q5_lon_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg <= v_reg[PIPE_LEN-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            if (meta_reg[PIPE_LEN-1].op == OP_INV)
            begin
                x_out_reg   <= '0;
                y_out_reg   <= '0;
                lat_out_reg <= q6_lat_reg;
                lon_out_reg <= q6_lon_reg;
            end
            else
            begin
                x_out_reg   <= q6_x_reg;
                y_out_reg   <= q6_y_reg;
                lat_out_reg <= '0;
                lon_out_reg <= '0;
            end
            elev_out_reg     <= meta_reg[PIPE_LEN-1].elev;
            domain_error_reg <= meta_reg[PIPE_LEN-1].err;
        end
    end

    assign out_valid    = out_valid_reg;
    assign x_out        = x_out_reg;
    assign y_out        = y_out_reg;
    assign lat_out      = lat_out_reg;
    assign lon_out      = lon_out_reg;
    assign elev_out     = elev_out_reg;
    assign domain_error = domain_error_reg;

endmodule

// ----- design/lap_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the local aligned projection, bound to the top level
`include "assert_macros.svh"

module lap_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] x_out,
    input logic signed [31:0] y_out,
    input logic signed [31:0] lat_out,
    input logic signed [31:0] lon_out,
    input logic               domain_error
);

    `LAP_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")
    `LAP_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |-> !out_valid, "result shown during reset")
    `LAP_ASSERT(a_free_accept, clk, rst_n, !out_valid |-> !in_stall, "input stalled with empty output")
    `LAP_ASSERT(a_one_side, clk, rst_n, out_valid |-> (x_out == 0 && y_out == 0) || (lat_out == 0 && lon_out == 0 && !domain_error), "both result sides set")

endmodule

bind local_aligned_projection_top lap_checker u_lap_checker (.*);

// ----- test/tb_local_aligned_projection_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the local aligned projection top level
module tb_local_aligned_projection_top;
    import lap_pkg::*;

    localparam int STAGES    = 24;
    localparam int ABITS     = 32;
    localparam int LATENCY   = 44 + STAGES;
    localparam int LONG_HOLD = 400;
    localparam longint RADIUS  = 6378137;
    localparam longint UNIT    = 64'sd1073741824;
    localparam logic [2:0] REG_SPARE = 3'd6;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] lat;
        logic [31:0] lon;
        logic [31:0] elev;
        logic        err;
    } fix_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               op = OP_FWD;
    logic signed [31:0] lat_in = '0;
    logic signed [31:0] lon_in = '0;
    logic signed [31:0] x_in = '0;
    logic signed [31:0] y_in = '0;
    logic signed [31:0] elev_in = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] lat_out;
    logic signed [31:0] lon_out;
    logic signed [31:0] elev_out;
    logic               domain_error;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    // shadow registers
    logic signed [31:0] org_lat, org_lon, hd_cos, hd_sin;
    logic [30:0]        lscale;
    logic [31:0]        lscale_inv;

    fix_t   pending_fixes[$];
    int     mismatches = 0;
    bit     idle_en = 1'b1;
    bit     long_hold_req = 1'b0;

    longint arctan_q[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0};

    local_aligned_projection_top #(.CORDIC_STAGES(STAGES), .ANGLE_BITS(ABITS)) u_top (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic longint rshr(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint angle_cut(longint a);
        logic [31:0] u;
        logic [31:0] m;
        u = a[31:0];
        m = 32'hFFFF_FFFF << (32 - ABITS);
        return longint'($signed(u & m));
    endfunction

    function automatic longint sine_q30(longint a);
        longint x, y, z, nx;
        x = 652032874;
        y = 0;
        a = angle_cut(a);
        if (a > UNIT)
            a = 2 * UNIT - a;
        else if (a < -UNIT)
            a = -2 * UNIT - a;
        z = a;
        for (int i = 0; i < STAGES && i < 32; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= arctan_q[i];
            end
            else
            begin
                nx = x + (y >>> i); y = y - (x >>> i); z += arctan_q[i];
            end
            x = nx;
        end
        return clamp(y, -UNIT, UNIT);
    endfunction

    function automatic longint int_sqrt(logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b); r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint arcsine(longint a);
        longint x, y, z, nx;
        x = int_sqrt((64'd1 << 60) - 64'(a * a));
        y = a;
        z = 0;
        for (int i = 0; i < STAGES && i < 32; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i); y = y - (x >>> i); z += arctan_q[i];
            end
            else
            begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= arctan_q[i];
            end
            x = nx;
        end
        return angle_cut(z);
    endfunction

    function automatic longint metres_to_arg(longint v, ref logic err);
        longint a;
        a = (v * 16777216) / RADIUS;
        if (a > UNIT)
        begin
            err = 1'b1; return UNIT;
        end
        if (a < -UNIT)
        begin
            err = 1'b1; return -UNIT;
        end
        return a;
    endfunction

    function automatic fix_t project_point(logic dir, logic signed [31:0] la,
                                           logic signed [31:0] lo, logic signed [31:0] xi,
                                           logic signed [31:0] yi, logic [31:0] el);
        fix_t f;
        longint c, s, sl, so, p, x, y, ax, ay, dlat, dlon;
        logic signed [31:0] d;
        logic e;
        c = clamp(longint'(hd_cos), -UNIT, UNIT);
        s = clamp(longint'(hd_sin), -UNIT, UNIT);
        f = '0;
        f.elev = el;
        if (dir == OP_FWD)
        begin
            d = la - org_lat;
            sl = sine_q30(longint'(d));
            d = lo - org_lon;
            so = sine_q30(longint'(d));
            p = rshr(so * longint'(lscale), 30);
            y = rshr(sl * RADIUS, 24);
            x = rshr(p * RADIUS, 24);
            f.x = 32'(clamp(rshr(x * c - y * s, 30), -64'sd2147483648, 64'sd2147483647));
            f.y = 32'(clamp(rshr(x * s + y * c, 30), -64'sd2147483648, 64'sd2147483647));
        end
        else
        begin
            e = 1'b0;
            x = rshr(longint'(xi) * c + longint'(yi) * s, 30);
            y = rshr(longint'(yi) * c - longint'(xi) * s, 30);
            ay = metres_to_arg(y, e);
            ax = metres_to_arg(x, e);
            dlat = arcsine(ay);
            dlon = rshr(arcsine(ax) * longint'(lscale_inv), 24);
            f.lat = org_lat + dlat[31:0];
            f.lon = org_lon + dlon[31:0];
            f.err = e;
        end
        return f;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ORIGIN_LAT:    org_lat = val;
            REG_ORIGIN_LON:    org_lon = val;
            REG_HEADING_COS:   hd_cos = val;
            REG_HEADING_SIN:   hd_sin = val;
            REG_LON_SCALE:     lscale = val[30:0];
            REG_LON_SCALE_INV: lscale_inv = val;
            default: ;
        endcase
    endtask

    task automatic send_point(logic dir, logic [31:0] la, logic [31:0] lo,
                              logic [31:0] xi, logic [31:0] yi, logic [31:0] el);
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= dir;
        lat_in   <= la;
        lon_in   <= lo;
        x_in     <= xi;
        y_in     <= yi;
        elev_in  <= el;
        do
            @(posedge clk);
        while (in_stall);
        pending_fixes.push_back(project_point(dir, la, lo, xi, yi, el));
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
        while (pending_fixes.size() != 0)
            @(posedge clk);
    endtask

    // results never go missing, but the pipe may still hold work in flight
    task automatic drain();
        end_burst();
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic send_random(int n);
        logic [31:0] a, b;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    a = $urandom; b = $urandom;
                end
                else
                begin
                    a = org_lat + ($urandom_range(0, 400000000) - 200000000);
                    b = org_lon + ($urandom_range(0, 400000000) - 200000000);
                end
                send_point(OP_FWD, a, b, $urandom, $urandom, $urandom);
            end
            else
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    a = $urandom; b = $urandom;
                end
                else
                begin
                    a = $urandom_range(0, 800000000) - 400000000;
                    b = $urandom_range(0, 800000000) - 400000000;
                end
                send_point(OP_INV, $urandom, $urandom, a, b, $urandom);
            end
        end
    endtask

    task automatic test_directed();
        send_point(OP_FWD, 32'd0, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF);
        send_point(OP_FWD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0, 32'h8000_0000);
        send_point(OP_FWD, 32'h8000_0000, 32'h8000_0000, '0, '0, 32'd0);
        send_point(OP_FWD, 32'h4000_0000, 32'hC000_0000, '0, '0, 32'hFFFF_FFFF);
        send_point(OP_FWD, 32'h4000_1000, 32'hBFFF_F000, '0, '0, 32'd1);
        send_point(OP_FWD, 32'h0100_0000, 32'hFF00_0000, 32'hFFFF_FFFF, '0, 32'd5);
        send_point(OP_INV, '0, '0, 32'd0, 32'd0, 32'd7);
        send_point(OP_INV, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd8);
        send_point(OP_INV, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd9);
        send_point(OP_INV, '0, '0, 32'(SAT_LIMIT), 32'(SAT_LIMIT - 1), 32'd10);
        send_point(OP_INV, '0, '0, -32'(SAT_LIMIT), -32'(SAT_LIMIT - 1), 32'd11);
        send_point(OP_INV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd100000000, -32'd100000000, 32'd12);
        send_point(OP_INV, '0, '0, 32'd1, -32'd1, 32'd13);
        drain();
    endtask

    task automatic test_settings();
        // extremes of every register, including out-of-range headings
        write_reg(REG_ORIGIN_LAT, 32'h7FFF_FFFF);
        write_reg(REG_ORIGIN_LON, 32'h8000_0000);
        write_reg(REG_HEADING_COS, 32'h7FFF_FFFF);
        write_reg(REG_HEADING_SIN, 32'h8000_0000);
        write_reg(REG_LON_SCALE, 32'hFFFF_FFFF);
        write_reg(REG_LON_SCALE_INV, 32'hFFFF_FFFF);
        write_reg(REG_SPARE, 32'h1234_5678);
        send_random(250);
        drain();
        write_reg(REG_ORIGIN_LAT, 32'h8000_0000);
        write_reg(REG_ORIGIN_LON, 32'h7FFF_FFFF);
        write_reg(REG_HEADING_COS, 32'hC000_0000);
        write_reg(REG_HEADING_SIN, 32'h4000_0000);
        write_reg(REG_LON_SCALE, 32'd0);
        write_reg(REG_LON_SCALE_INV, 32'd0);
        send_random(250);
        drain();
        write_reg(REG_HEADING_COS, 32'd0);
        write_reg(REG_HEADING_SIN, 32'hC000_0000);
        write_reg(REG_LON_SCALE, 32'h4000_0000);
        write_reg(REG_LON_SCALE_INV, 32'h0100_0000);
        send_random(250);
        drain();
        for (int k = 0; k < 3; k++)
        begin
            write_reg(REG_ORIGIN_LAT, $urandom);
            write_reg(REG_ORIGIN_LON, $urandom);
            write_reg(REG_HEADING_COS, $urandom_range(0, 32'h8000_0000) - 32'h4000_0000);
            write_reg(REG_HEADING_SIN, $urandom_range(0, 32'h8000_0000) - 32'h4000_0000);
            write_reg(REG_LON_SCALE, $urandom_range(0, 32'h4000_0000));
            write_reg(REG_LON_SCALE_INV, $urandom);
            send_random(250);
            drain();
        end
    endtask

    task automatic test_backpressure();
        long_hold_req = 1'b1;
        send_random(200);
        end_burst();
        send_random(50);
        // sender waits for every result before going on
        end_burst();
        send_random(50);
        drain();
    endtask

    task automatic test_no_idle();
        idle_en = 1'b0;
        send_random(100);
        drain();
    endtask

    initial
    begin
        org_lat = '0; org_lon = '0;
        hd_cos = 32'h4000_0000; hd_sin = '0;
        lscale = 31'h4000_0000; lscale_inv = 32'h0100_0000;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_settings();
        test_backpressure();
        test_no_idle();
        if (mismatches == 0 && pending_fixes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // output stall: random bursts, or one long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                for (int n = 0; n < LONG_HOLD; n++)
                    @(posedge clk);
                long_hold_req = 1'b0;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        fix_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{x_out, y_out, lat_out, lon_out, elev_out, domain_error};
            if (pending_fixes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: %h", got);
            end
            else
            begin
                want = pending_fixes.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%h y=%h lat=%h lon=%h el=%h err=%b",
                                 want.x, want.y, want.lat, want.lon, want.elev, want.err,
                                 "\n          got x=%h y=%h lat=%h lon=%h el=%h err=%b",
                                 got.x, got.y, got.lat, got.lon, got.elev, got.err);
                end
            end
        end
    end

endmodule
